@@ sv/tlb_pkg.sv @@
// Package for the 4 KB page translation buffer: commands, status codes,
// entry type and sizing constants. No dependencies.
package tlb_pkg;

  localparam int unsigned TlbEntriesDefault = 32;
  localparam int unsigned TlbSafeDefault    = 8;
  localparam int unsigned TlbIdxW           = 5;
  localparam int unsigned TlbQDepth         = 2;

  typedef enum logic [2:0] {
    CMD_TRANSLATE = 3'd0,
    CMD_GQUERY    = 3'd1,
    CMD_PROBE     = 3'd2,
    CMD_READ      = 3'd3,
    CMD_WRITE_IDX = 3'd4,
    CMD_WRITE_RND = 3'd5
  } tlb_cmd_t;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_NOMATCH  = 2'd1,
    ST_INVALID  = 2'd2,
    ST_MODIFIED = 2'd3
  } tlb_status_t;

  typedef struct packed {
    logic [19:0] vpn;
    logic [5:0]  pid;
    logic [19:0] pfn;
    logic        n;
    logic        d;
    logic        v;
    logic        g;
  } tlb_entry_t;

  // One classified word handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]         cmd;
    logic               known;
    logic [11:0]        offset;
    logic               is_write;
    logic               found;
    logic [TlbIdxW-1:0] hit_idx;
    logic [TlbIdxW-1:0] index;
    logic               idx_ok;
    tlb_entry_t         hit_e;
    tlb_entry_t         rd_e;
  } tlb_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] paddr;
    logic        is_global;
    logic        probe_fail;
    logic [4:0]  index_out;
    tlb_entry_t  rd;
  } tlb_res_t;

endpackage

@@ sv/tlb_ifc.sv @@
// Valid/ready channel interfaces for the translation buffer.
// No dependencies.
interface tlb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] vaddr;
  logic        is_write;
  logic [19:0] vpn;
  logic [5:0]  pid;
  logic [4:0]  index;
  logic [19:0] pfn;
  logic        flag_n;
  logic        flag_d;
  logic        flag_v;
  logic        flag_g;
  modport source (output valid, cmd, vaddr, is_write, vpn, pid, index, pfn,
                  flag_n, flag_d, flag_v, flag_g, input ready);
  modport sink (input valid, cmd, vaddr, is_write, vpn, pid, index, pfn,
                flag_n, flag_d, flag_v, flag_g, output ready);
endinterface

interface tlb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] paddr;
  logic        is_global;
  logic        probe_fail;
  logic [4:0]  index_out;
  logic [19:0] rd_vpn;
  logic [5:0]  rd_pid;
  logic [19:0] rd_pfn;
  logic        rd_n;
  logic        rd_d;
  logic        rd_v;
  logic        rd_g;
  modport source (output valid, status, paddr, is_global, probe_fail, index_out,
                  rd_vpn, rd_pid, rd_pfn, rd_n, rd_d, rd_v, rd_g, input ready);
  modport sink (input valid, status, paddr, is_global, probe_fail, index_out,
                rd_vpn, rd_pid, rd_pfn, rd_n, rd_d, rd_v, rd_g, output ready);
endinterface

interface tlb_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/tlb_front.sv @@
// Front part: holds the entry array, matches, reads and writes it, and
// emits a classified word. Depends on tlb_pkg.
module tlb_front import tlb_pkg::*; #(
  parameter int unsigned ENTRIES      = TlbEntriesDefault,
  parameter int unsigned SAFE_ENTRIES = TlbSafeDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [2:0]  cmd,
  input  logic [31:0] vaddr,
  input  logic        is_write,
  input  logic [19:0] vpn,
  input  logic [5:0]  pid,
  input  logic [4:0]  index,
  input  tlb_entry_t  wr_e,
  output tlb_op_t     op
);

  localparam logic [TlbIdxW-1:0] LastSlot = TlbIdxW'(ENTRIES - 1);
  localparam logic [TlbIdxW-1:0] SafeSlot = TlbIdxW'(SAFE_ENTRIES);

  // Valid bits stand for the cleared reset value of each entry.
  tlb_entry_t         ent_r [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  logic [TlbIdxW-1:0] rnd_r;
  logic [TlbIdxW-1:0] rnd_nxt;
  logic [19:0]        page;
  logic [ENTRIES-1:0] match;
  logic               found;
  logic [TlbIdxW-1:0] hit_idx;
  logic               idx_ok;
  logic               do_wr;
  logic [TlbIdxW-1:0] wr_slot;

  function automatic tlb_entry_t rd_ent(input tlb_entry_t e, input logic v);
    tlb_entry_t z;
    z = '0;
    return v ? e : z;
  endfunction

  assign page   = (cmd == CMD_PROBE) ? vpn : vaddr[31:12];
  assign idx_ok = (32'(index) < ENTRIES);

  always_comb begin
    tlb_entry_t e;
    for (int i = 0; i < ENTRIES; i++) begin
      e = rd_ent(ent_r[i], vld_r[i]);
      match[i] = (e.vpn == page) && (e.g || e.pid == pid);
    end
  end

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found   = 1'b1;
        hit_idx = TlbIdxW'(i);
      end
    end
  end

  always_comb begin
    rnd_nxt = rnd_r;
    do_wr   = 1'b0;
    wr_slot = index;
    if (acc && cmd == CMD_WRITE_IDX) begin
      do_wr = idx_ok;
    end else if (acc && cmd == CMD_WRITE_RND) begin
      do_wr   = 1'b1;
      wr_slot = rnd_r;
      rnd_nxt = (rnd_r <= SafeSlot) ? LastSlot : rnd_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rnd_r <= LastSlot;
    end else begin
      rnd_r <= rnd_nxt;
      if (do_wr) begin
        vld_r[wr_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_slot] <= wr_e;
    end
  end

  always_comb begin
    op          = '0;
    op.cmd      = cmd;
    op.known    = (cmd <= CMD_WRITE_RND);
    op.offset   = vaddr[11:0];
    op.is_write = is_write;
    op.found    = found;
    op.hit_idx  = hit_idx;
    op.index    = (cmd == CMD_WRITE_RND) ? rnd_r : index;
    op.idx_ok   = idx_ok;
    op.hit_e    = rd_ent(ent_r[hit_idx], vld_r[hit_idx]);
    if (idx_ok) begin
      op.rd_e = rd_ent(ent_r[index], vld_r[index]);
    end
  end

endmodule

@@ sv/tlb_queue.sv @@
// Short queue of classified words between front and back parts.
// Depends on tlb_pkg.
module tlb_queue import tlb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  tlb_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output tlb_op_t head
);

  localparam int unsigned PtrW = $clog2(TlbQDepth);

  tlb_op_t         mem_r [TlbQDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;

  assign full  = (cnt_r == (PtrW+1)'(TlbQDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_op;
    end
  end

endmodule

@@ sv/tlb_back.sv @@
// Back part: turns a classified word into a result word and holds it in
// the output register. Depends on tlb_pkg.
module tlb_back import tlb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     have,
  input  tlb_op_t  op,
  input  logic     cfg_we,
  input  logic [31:0] cfg_data,
  output logic     take,
  output logic     res_valid,
  input  logic     res_ready,
  output tlb_res_t res
);

  logic [31:0] mask_r;
  logic        vld_r;
  tlb_res_t    res_r, res_nxt;

  assign take      = have && (!vld_r || res_ready);
  assign res_valid = vld_r;
  assign res       = res_r;

  always_comb begin
    res_nxt = '0;
    if (op.known) begin
      unique case (op.cmd)
        CMD_TRANSLATE: begin
          if (!op.found) res_nxt.status = ST_NOMATCH;
          else if (!op.hit_e.v) res_nxt.status = ST_INVALID;
          else if (op.is_write && !op.hit_e.d) res_nxt.status = ST_MODIFIED;
          else res_nxt.paddr = {op.hit_e.pfn, op.offset} & mask_r;
        end
        CMD_GQUERY: res_nxt.is_global = op.found && op.hit_e.g;
        CMD_PROBE: begin
          res_nxt.probe_fail = !op.found;
          res_nxt.index_out  = op.found ? op.hit_idx : op.index;
        end
        CMD_READ:      res_nxt.rd = op.rd_e;
        CMD_WRITE_RND: res_nxt.index_out = op.index;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      mask_r <= '1;
    end else begin
      if (cfg_we) mask_r <= cfg_data;
      if (take) vld_r <= 1'b1;
      else if (res_ready) vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

endmodule

@@ sv/tlb_assoc_4k_page.sv @@
// Top level of the fully associative 4 KB page translation buffer.
// Depends on tlb_pkg, tlb_ifc, tlb_front, tlb_queue and tlb_back.
//
//   channel  direction  carries
//   in       sink       one command word (translate, query, probe, read, writes)
//   out      source     one result word per command
//   cfg      sink       physical address mask
//
// Each command is matched against all entries in the cycle it is accepted.
// The word is queued at that edge and moves into the output register once that
// register is free. The sustained rate is one word per cycle while the output
// does not stall. The two-deep queue between the lookup and the output register
// lets input and output stall independently. Reset clears all entries (through
// per-entry valid bits), sets the random slot counter to the last entry and the
// mask to all ones.
module tlb_assoc_4k_page import tlb_pkg::*; #(
  parameter int unsigned ENTRIES      = TlbEntriesDefault,
  parameter int unsigned SAFE_ENTRIES = TlbSafeDefault
) (
  input logic clk,
  input logic rst_n,
  tlb_in_if.sink    in_ch,
  tlb_out_if.source out_ch,
  tlb_cfg_if.sink   cfg_ch
);

  tlb_op_t    f_op, q_head;
  tlb_res_t   res;
  tlb_entry_t wr_e;
  logic       q_full, q_empty, take, acc;

  // The front writes and looks up in the accept cycle, so commands enter
  // the queue strictly in order.
  assign in_ch.ready  = !q_full;
  assign acc          = in_ch.valid && !q_full;
  assign cfg_ch.ready = 1'b1;

  assign wr_e = '{vpn: in_ch.vpn, pid: in_ch.pid, pfn: in_ch.pfn, n: in_ch.flag_n,
                  d: in_ch.flag_d, v: in_ch.flag_v, g: in_ch.flag_g};

  tlb_front #(.ENTRIES(ENTRIES), .SAFE_ENTRIES(SAFE_ENTRIES)) u_front (
    .clk, .rst_n, .acc, .cmd(in_ch.cmd), .vaddr(in_ch.vaddr),
    .is_write(in_ch.is_write), .vpn(in_ch.vpn), .pid(in_ch.pid),
    .index(in_ch.index), .wr_e, .op(f_op)
  );

  tlb_queue u_queue (
    .clk, .rst_n, .push(acc), .push_op(f_op), .full(q_full),
    .pop(take), .empty(q_empty), .head(q_head)
  );

  tlb_back u_back (
    .clk, .rst_n, .have(!q_empty), .op(q_head),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data), .take,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.status     = res.status;
  assign out_ch.paddr      = res.paddr;
  assign out_ch.is_global  = res.is_global;
  assign out_ch.probe_fail = res.probe_fail;
  assign out_ch.index_out  = res.index_out;
  assign out_ch.rd_vpn     = res.rd.vpn;
  assign out_ch.rd_pid     = res.rd.pid;
  assign out_ch.rd_pfn     = res.rd.pfn;
  assign out_ch.rd_n       = res.rd.n;
  assign out_ch.rd_d       = res.rd.d;
  assign out_ch.rd_v       = res.rd.v;
  assign out_ch.rd_g       = res.rd.g;

endmodule

@@ sv/tlb_checker.sv @@
// Port-level checks for the translation buffer, bound to the top level.
// Depends on tlb_pkg.
module tlb_checker import tlb_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [31:0] paddr,
  input logic       probe_fail,
  input logic       is_global
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(paddr))
    else $error("result word dropped while stalled");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_HIT |-> paddr == '0)
    else $error("address given on a failed translate");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(probe_fail && is_global) && !(probe_fail && status != ST_HIT))
    else $error("result fields of different commands mixed");

endmodule

bind tlb_assoc_4k_page tlb_checker u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .paddr(out_ch.paddr),
  .probe_fail(out_ch.probe_fail), .is_global(out_ch.is_global)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the 4 KB page translation buffer (tlb_assoc_4k_page).
// A directed table runs first, then weighted random commands. Both are checked
// against a behavioral model of the buffer. Depends on tlb_pkg and the channel interfaces.
module testbench;
  import tlb_pkg::*;

  localparam int Entries = 32;
  localparam int SafeEntries = 8;
  localparam int RandomWords = 750;

  // One command word as it is driven on the input channel.
  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] vaddr;
    logic        is_write;
    logic [19:0] vpn;
    logic [5:0]  pid;
    logic [4:0]  index;
    logic [19:0] pfn;
    logic [3:0]  flags;  // n, d, v, g
  } cmd_word_t;

  // One row of the directed table. When has_exp is set, the typed-in result
  // must agree with the model's result as well as with the block's result.
  typedef struct {
    cmd_word_t w;
    bit        has_exp;
    tlb_res_t  exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlb_in_if  in_ch ();
  tlb_out_if out_ch ();
  tlb_cfg_if cfg_ch ();

  tlb_assoc_4k_page dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #2 clk = ~clk;

  // Model state: the entry array, the random slot counter and the address mask.
  tlb_entry_t  mdl_entry [Entries];
  logic [4:0]  mdl_rnd_slot;
  logic [31:0] mdl_mask;

  tlb_res_t expected_results [$];
  int       mismatches = 0;
  bit       stim_done = 1'b0;

  // Returns the lowest index that matches the page under pid, or -1.
  function automatic int find_entry(logic [19:0] page, logic [5:0] pid);
    for (int i = 0; i < Entries; i++) begin
      if (mdl_entry[i].vpn == page && (mdl_entry[i].g || mdl_entry[i].pid == pid)) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Computes the result word of one command and updates the model state.
  function automatic tlb_res_t translate_word(cmd_word_t w);
    tlb_res_t   r;
    tlb_entry_t e;
    int         hit;
    r = '0;
    e = '{vpn: w.vpn, pid: w.pid, pfn: w.pfn, n: w.flags[3], d: w.flags[2],
          v: w.flags[1], g: w.flags[0]};
    case (w.cmd)
      CMD_TRANSLATE: begin
        hit = find_entry(w.vaddr[31:12], w.pid);
        if (hit < 0) begin
          r.status = ST_NOMATCH;
        end else if (!mdl_entry[hit].v) begin
          r.status = ST_INVALID;
        end else if (w.is_write && !mdl_entry[hit].d) begin
          r.status = ST_MODIFIED;
        end else begin
          r.status = ST_HIT;
          r.paddr = {mdl_entry[hit].pfn, w.vaddr[11:0]} & mdl_mask;
        end
      end
      CMD_GQUERY: begin
        hit = find_entry(w.vaddr[31:12], w.pid);
        r.is_global = (hit >= 0) && mdl_entry[hit].g;
      end
      CMD_PROBE: begin
        hit = find_entry(w.vpn, w.pid);
        if (hit < 0) begin
          r.probe_fail = 1'b1;
          r.index_out = w.index;
        end else begin
          r.index_out = hit[4:0];
        end
      end
      CMD_READ: begin
        if (w.index < Entries) r.rd = mdl_entry[w.index];
      end
      CMD_WRITE_IDX: begin
        if (w.index < Entries) mdl_entry[w.index] = e;
      end
      CMD_WRITE_RND: begin
        mdl_entry[mdl_rnd_slot] = e;
        r.index_out = mdl_rnd_slot;
        // The counter steps down and wraps to the top before the safe entries.
        if (mdl_rnd_slot <= SafeEntries) mdl_rnd_slot = 5'(Entries - 1);
        else mdl_rnd_slot = mdl_rnd_slot - 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Reports a mismatch. Only the first ten are printed, the rest are counted.
  task automatic note_mismatch(string what, tlb_res_t e, tlb_res_t a);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: expected st=%0d pa=%h g=%b pf=%b ix=%0d rd=%h",
               what, e.status, e.paddr, e.is_global, e.probe_fail, e.index_out, e.rd);
      $display("           actual st=%0d pa=%h g=%b pf=%b ix=%0d rd=%h",
               a.status, a.paddr, a.is_global, a.probe_fail, a.index_out, a.rd);
    end
  endtask

  // Drives one command word and holds it until the handshake. The gap before
  // the word is drawn at random, so idle cycles fall on every phase.
  task automatic send_word(cmd_word_t w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= w.cmd;
    in_ch.vaddr    <= w.vaddr;
    in_ch.is_write <= w.is_write;
    in_ch.vpn      <= w.vpn;
    in_ch.pid      <= w.pid;
    in_ch.index    <= w.index;
    in_ch.pfn      <= w.pfn;
    {in_ch.flag_n, in_ch.flag_d, in_ch.flag_v, in_ch.flag_g} <= w.flags;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(translate_word(w));
  endtask

  // Lowers valid and waits until every expected word has arrived, so that
  // the block is idle before the mask is written.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(logic [31:0] m);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    mdl_mask = m;
  endtask

  function automatic cmd_word_t mk(logic [2:0] c, logic [31:0] va, logic wr,
                                   logic [19:0] vp, logic [5:0] pd, logic [4:0] ix,
                                   logic [19:0] pf, logic [3:0] fl);
    cmd_word_t w;
    w = '{cmd: c, vaddr: va, is_write: wr, vpn: vp, pid: pd, index: ix, pfn: pf, flags: fl};
    return w;
  endfunction

  // Random word. A small pool of pages and pids makes hits and shadowed
  // entries common. Some words use fully random values as noise.
  function automatic cmd_word_t rand_word();
    cmd_word_t w;
    logic [19:0] page;
    int sel;
    page = ($urandom_range(0, 5) == 0) ? 20'($urandom) : 20'($urandom_range(0, 7) * 20'h1111);
    w = mk(3'($urandom), $urandom, 1'($urandom), page, 6'($urandom_range(0, 3)),
           5'($urandom), 20'($urandom), 4'($urandom));
    if ($urandom_range(0, 4) == 0) w.pid = 6'($urandom);
    w.vaddr[31:12] = page;
    sel = $urandom_range(0, 99);
    if (sel < 30) w.cmd = CMD_TRANSLATE;
    else if (sel < 40) w.cmd = CMD_GQUERY;
    else if (sel < 50) w.cmd = CMD_PROBE;
    else if (sel < 62) w.cmd = CMD_READ;
    else if (sel < 80) w.cmd = CMD_WRITE_IDX;
    else if (sel < 95) w.cmd = CMD_WRITE_RND;
    return w;
  endfunction

  // Output side. The receiver stalls at random, and each accepted word is
  // checked against the oldest expectation.
  initial begin
    tlb_res_t got;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{status: out_ch.status, paddr: out_ch.paddr, is_global: out_ch.is_global,
              probe_fail: out_ch.probe_fail, index_out: out_ch.index_out,
              rd: '{vpn: out_ch.rd_vpn, pid: out_ch.rd_pid, pfn: out_ch.rd_pfn,
                    n: out_ch.rd_n, d: out_ch.rd_d, v: out_ch.rd_v, g: out_ch.rd_g}};
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else if (got !== expected_results[0]) begin
        note_mismatch("result", expected_results[0], got);
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // Stimulus.
  initial begin
    dir_row_t rows [$];
    tlb_res_t m;
    tlb_res_t hit_exp;
    tlb_res_t miss_exp;
    tlb_res_t inv_exp;
    tlb_res_t mod_exp;
    tlb_res_t zero_exp;
    logic [31:0] masks [4];

    in_ch.valid = 1'b0;
    in_ch.cmd = '0; in_ch.vaddr = '0; in_ch.is_write = 1'b0; in_ch.vpn = '0;
    in_ch.pid = '0; in_ch.index = '0; in_ch.pfn = '0;
    in_ch.flag_n = 1'b0; in_ch.flag_d = 1'b0; in_ch.flag_v = 1'b0; in_ch.flag_g = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    foreach (mdl_entry[i]) mdl_entry[i] = '0;
    mdl_rnd_slot = 5'(Entries - 1);
    mdl_mask = '1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    zero_exp = '0;
    miss_exp = '0; miss_exp.status = ST_NOMATCH;
    inv_exp  = '0; inv_exp.status = ST_INVALID;
    mod_exp  = '0; mod_exp.status = ST_MODIFIED;
    hit_exp  = '0; hit_exp.paddr = 32'hFFFF_FFFF;

    // The directed table. After reset every entry is zero, so page 0 with
    // pid 0 matches entry 0, which is invalid.
    rows.push_back('{mk(CMD_TRANSLATE, 32'h0000_0123, 0, 0, 0, 0, 0, 0), 1, inv_exp});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0, 31, 0, 0), 1, zero_exp});
    rows.push_back('{mk(CMD_TRANSLATE, 32'hFFFF_FFFF, 1, 0, 63, 0, 0, 0), 1, miss_exp});
    rows.push_back('{mk(CMD_WRITE_IDX, 0, 0, 20'hFFFFF, 63, 0, 20'hFFFFF, 4'b1111), 1, zero_exp});
    rows.push_back('{mk(CMD_TRANSLATE, 32'hFFFF_FFFF, 1, 0, 5, 0, 0, 0), 1, hit_exp});
    rows.push_back('{mk(CMD_GQUERY, 32'hFFFF_F000, 0, 0, 9, 0, 0, 0), 0, zero_exp});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0), 0, zero_exp});
    // Store to a clean page, and an invalid entry that shadows a valid one.
    rows.push_back('{mk(CMD_WRITE_IDX, 0, 0, 20'h12345, 7, 3, 20'hABCDE, 4'b0010), 0, zero_exp});
    rows.push_back('{mk(CMD_TRANSLATE, 32'h1234_5FFF, 1, 0, 7, 0, 0, 0), 1, mod_exp});
    rows.push_back('{mk(CMD_TRANSLATE, 32'h1234_5FFF, 0, 0, 7, 0, 0, 0), 0, zero_exp});
    rows.push_back('{mk(CMD_WRITE_IDX, 0, 0, 20'h12345, 7, 1, 20'h11111, 4'b0000), 0, zero_exp});
    rows.push_back('{mk(CMD_TRANSLATE, 32'h1234_5000, 0, 0, 7, 0, 0, 0), 1, inv_exp});
    rows.push_back('{mk(CMD_TRANSLATE, 32'h1234_5000, 0, 0, 8, 0, 0, 0), 1, miss_exp});
    // Probe hit and miss. On a miss the input index comes back.
    rows.push_back('{mk(CMD_PROBE, 0, 0, 20'h12345, 7, 30, 0, 0), 0, zero_exp});
    rows.push_back('{mk(CMD_PROBE, 0, 0, 20'h54321, 7, 30, 0, 0), 0, zero_exp});
    // Write random walks down from the last entry.
    rows.push_back('{mk(CMD_WRITE_RND, 0, 0, 20'h00001, 0, 0, 20'h00002, 4'b1001), 0, zero_exp});
    rows.push_back('{mk(CMD_WRITE_RND, 0, 0, 20'h00001, 1, 0, 20'h00003, 4'b0110), 0, zero_exp});
    rows.push_back('{mk(CMD_GQUERY, 32'h0000_1000, 0, 0, 33, 0, 0, 0), 0, zero_exp});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0, 30, 0, 0), 0, zero_exp});
    // The unused command codes change nothing and return zero.
    rows.push_back('{mk(3'd6, 32'hFFFF_FFFF, 1, 20'hFFFFF, 63, 31, 20'hFFFFF, 4'b1111), 1, zero_exp});
    rows.push_back('{mk(3'd7, 32'hFFFF_FFFF, 1, 20'hFFFFF, 63, 31, 20'hFFFFF, 4'b1111), 1, zero_exp});

    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        // Check the typed-in value against the model without disturbing its state.
        tlb_entry_t  save_e [Entries];
        logic [4:0]  save_slot;
        save_e = mdl_entry;
        save_slot = mdl_rnd_slot;
        m = translate_word(rows[i].w);
        mdl_entry = save_e;
        mdl_rnd_slot = save_slot;
        if (m !== rows[i].exp) note_mismatch("directed row", rows[i].exp, m);
      end
      send_word(rows[i].w);
    end

    // Random phases, each under its own mask. The extremes are included.
    masks[0] = 32'h0000_0000;
    masks[1] = 32'h0FFF_F0FF;
    masks[2] = $urandom;
    masks[3] = 32'hFFFF_FFFF;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_mask(masks[ph]);
      for (int k = 0; k < RandomWords / 4; k++) send_word(rand_word());
    end
    drain();
    stim_done = 1'b1;
  end

  // End of the run.
  initial begin
    wait (stim_done);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Timeout watchdog.
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
